### sv/mbsp_pkg.sv
// shared types, codes and status decode for the midi byte stream parser
package mbsp_pkg;

	localparam logic OP_FEED = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam logic [7:0] ST_SYSEX    = 8'hF0;
	localparam logic [7:0] ST_MTC      = 8'hF1;
	localparam logic [7:0] ST_SPP      = 8'hF2;
	localparam logic [7:0] ST_SONG_SEL = 8'hF3;
	localparam logic [7:0] ST_TUNE     = 8'hF6;
	localparam logic [7:0] ST_RT_BASE  = 8'hF8;
	localparam logic [7:0] ST_SYS_BASE = 8'hF0;

	localparam logic [3:0] NIB_NOTE_OFF  = 4'h8;
	localparam logic [3:0] NIB_NOTE_ON   = 4'h9;
	localparam logic [3:0] NIB_CTRL      = 4'hB;
	localparam logic [3:0] NIB_PROGRAM   = 4'hC;
	localparam logic [3:0] NIB_PRESSURE  = 4'hD;
	localparam logic [3:0] NIB_PITCH     = 4'hE;

	// message length in bytes, status included
	localparam logic [1:0] LEN_BAD   = 2'd0;
	localparam logic [1:0] LEN_ONE   = 2'd1;
	localparam logic [1:0] LEN_TWO   = 2'd2;
	localparam logic [1:0] LEN_THREE = 2'd3;

	typedef struct packed {
		logic [6:0] second;
		logic [6:0] first;
		logic [7:0] status;
	} msg_t;

	typedef struct packed {
		logic enq;
		logic err;
		msg_t msg;
	} parse_res_t;

	function automatic logic [1:0] status_len(input logic [7:0] s);
		logic [1:0] len;
		len = LEN_BAD;
		priority if (s >= ST_RT_BASE) begin
			len = LEN_ONE;
		end else if (s >= ST_SYS_BASE) begin
			priority if (s == ST_MTC || s == ST_SONG_SEL) begin
				len = LEN_TWO;
			end else if (s == ST_SPP) begin
				len = LEN_THREE;
			end else begin
				len = LEN_ONE;
			end
		end else begin
			unique case (s[7:4])
				NIB_PROGRAM, NIB_PRESSURE: len = LEN_TWO;
				NIB_NOTE_OFF, NIB_NOTE_ON, NIB_CTRL, NIB_PITCH: len = LEN_THREE;
				default: len = LEN_BAD;
			endcase
		end
		return len;
	endfunction

endpackage

### sv/mbsp_parser.sv
// running status parser that assembles messages from received bytes
module mbsp_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 feed,
	input  logic [7:0]           data_byte,
	output mbsp_pkg::parse_res_t res
);

	logic [7:0] running_q;
	logic [6:0] held0_q;
	logic [6:0] held1_q;
	logic [1:0] pos_q;
	logic [1:0] need_q;

	logic [7:0] running_d;
	logic [6:0] held0_d;
	logic [6:0] held1_d;
	logic [1:0] pos_d;
	logic [1:0] need_d;
	logic [1:0] len;
	logic [1:0] pos_inc;

	always_comb begin
		running_d = running_q;
		held0_d   = held0_q;
		held1_d   = held1_q;
		pos_d     = pos_q;
		need_d    = need_q;
		res       = '0;
		len       = mbsp_pkg::status_len(data_byte);
		pos_inc   = pos_q + 2'd1;
		if (feed) begin
			if (data_byte[7]) begin
				priority if (data_byte == mbsp_pkg::ST_SYSEX) begin
					running_d = '0;
					pos_d     = '0;
					need_d    = '0;
				end else if (len == mbsp_pkg::LEN_BAD) begin
					res.err = 1'b1;
				end else if (len == mbsp_pkg::LEN_ONE) begin
					res.enq        = 1'b1;
					res.msg.status = data_byte;
				end else begin
					running_d = data_byte;
					pos_d     = '0;
					need_d    = len - 2'd1;
				end
			end else if (running_q == '0 || need_q == '0) begin
				res.err = 1'b1;
			end else begin
				if (pos_q[0]) begin
					held1_d = data_byte[6:0];
				end else begin
					held0_d = data_byte[6:0];
				end
				pos_d = pos_inc;
				if (pos_inc >= need_q) begin
					res.enq        = 1'b1;
					res.msg.status = running_q;
					res.msg.first  = held0_d;
					res.msg.second = (need_q > 2'd1) ? held1_d : 7'd0;
					pos_d          = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= '0;
			held0_q   <= '0;
			held1_q   <= '0;
			pos_q     <= '0;
			need_q    <= '0;
		end else begin
			running_q <= running_d;
			held0_q   <= held0_d;
			held1_q   <= held1_d;
			pos_q     <= pos_d;
			need_q    <= need_d;
		end
	end

endmodule

### sv/mbsp_queue.sv
// message fifo with one memory, registered read data
module mbsp_queue #(
	parameter int DEPTH = 128,
	parameter int FW    = $clog2(DEPTH + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  mbsp_pkg::msg_t wr_data,
	input  logic           pop,
	output logic           full,
	output logic           empty,
	output logic [FW-1:0]  fill,
	output mbsp_pkg::msg_t rd_data
);

	localparam int PW = $clog2(DEPTH);

	mbsp_pkg::msg_t mem [DEPTH];
	mbsp_pkg::msg_t rd_q;
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [FW-1:0]  fill_q;
	logic           do_wr;
	logic           do_rd;

	assign full  = fill_q == FW'(DEPTH);
	assign empty = fill_q == '0;
	assign do_wr = wr_en && !full;
	assign do_rd = pop && !empty;
	assign fill    = fill_q;
	assign rd_data = rd_q;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_data;
		end
		if (do_rd) begin
			rd_q <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			fill_q <= fill_q + FW'(do_wr) - FW'(do_rd);
		end
	end

endmodule

### sv/midi_byte_stream_parser.sv
// top level: input stage, parser, message fifo, counters and result register
// an accepted input beat passes the input stage, then the result register
// throughput: one beat per cycle while no result beat is stalled
// a stalled result beat holds a full input stage and all parser, fifo state
// reset is asynchronous and clears control state, pointers and counters
// the message store is not cleared; the fill level guards every read
module midi_byte_stream_parser #(
	parameter int QUEUE_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        msg_valid,
	output logic [7:0]  msg_status,
	output logic [6:0]  msg_first,
	output logic [6:0]  msg_second,
	output logic [7:0]  queued_count,
	output logic [31:0] error_total,
	output logic [31:0] message_total
);

	localparam int FW = $clog2(QUEUE_DEPTH + 1);

	logic       valid_s1;
	logic       op_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	logic       hit_q;
	logic [31:0] err_cnt_q;
	logic [31:0] msg_cnt_q;

	logic                 adv;
	logic                 feed;
	logic                 pop;
	logic                 full;
	logic                 empty;
	logic [FW-1:0]        fill;
	mbsp_pkg::msg_t       rd_data;
	mbsp_pkg::parse_res_t pres;

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign feed     = adv && op_s1 == mbsp_pkg::OP_FEED;
	assign pop      = adv && op_s1 == mbsp_pkg::OP_POP;

	mbsp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.feed      (feed),
		.data_byte (byte_s1),
		.res       (pres)
	);

	mbsp_queue #(
		.DEPTH (QUEUE_DEPTH),
		.FW    (FW)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (pres.enq),
		.wr_data (pres.msg),
		.pop     (pop),
		.full    (full),
		.empty   (empty),
		.fill    (fill),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= op;
			byte_s1 <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			err_cnt_q   <= '0;
			msg_cnt_q   <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
				hit_q       <= pop && !empty;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
				hit_q       <= 1'b0;
			end
			if (pres.err || (pres.enq && full)) begin
				err_cnt_q <= err_cnt_q + 32'd1;
			end
			if (pres.enq && !full) begin
				msg_cnt_q <= msg_cnt_q + 32'd1;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign msg_valid     = hit_q;
	assign msg_status    = hit_q ? rd_data.status : 8'd0;
	assign msg_first     = hit_q ? rd_data.first : 7'd0;
	assign msg_second    = hit_q ? rd_data.second : 7'd0;
	assign queued_count  = 8'(fill);
	assign error_total   = err_cnt_q;
	assign message_total = msg_cnt_q;

`ifndef SYNTH
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= FW'(QUEUE_DEPTH))
		else $error("fifo fill above depth");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(message_total) && $stable(error_total)
			&& $stable(queued_count)))
		else $error("state moved while result beat stalled");

	a_hit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		hit_q |-> out_valid_q)
		else $error("message flag without result beat");

	a_pop_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty) |=> (fill == $past(fill) - FW'(1)))
		else $error("pop did not lower fill level");
`endif

endmodule

### sim/testbench.sv
// testbench for the midi byte stream parser: directed table, random beats, queue model check
module testbench;

	localparam int QUEUE_DEPTH = 128;
	localparam int STUCK_LIMIT = 1000;

	typedef struct packed {
		logic        msg_valid;
		logic [7:0]  msg_status;
		logic [6:0]  msg_first;
		logic [6:0]  msg_second;
		logic [7:0]  queued_count;
		logic [31:0] error_total;
		logic [31:0] message_total;
	} reply_t;

	typedef struct packed {
		logic       op_bit;
		logic [7:0] value;
		logic       typed;
		reply_t     want;
	} dir_row_t;

	localparam logic [3:0] CHAN_NIBS [6] = '{mbsp_pkg::NIB_NOTE_OFF, mbsp_pkg::NIB_NOTE_ON,
		mbsp_pkg::NIB_CTRL, mbsp_pkg::NIB_PROGRAM, mbsp_pkg::NIB_PRESSURE,
		mbsp_pkg::NIB_PITCH};

	localparam int DIR_ROWS = 25;
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{mbsp_pkg::OP_POP, 8'h00, 1'b1, '{1'b0, 8'h00, 7'h00, 7'h00, 8'd0, 32'd0, 32'd0}},
		'{mbsp_pkg::OP_FEED, 8'h00, 1'b1, '{1'b0, 8'h00, 7'h00, 7'h00, 8'd0, 32'd1, 32'd0}},
		'{mbsp_pkg::OP_FEED, 8'h7F, 1'b1, '{1'b0, 8'h00, 7'h00, 7'h00, 8'd0, 32'd2, 32'd0}},
		'{mbsp_pkg::OP_FEED, 8'hA5, 1'b1, '{1'b0, 8'h00, 7'h00, 7'h00, 8'd0, 32'd3, 32'd0}},
		'{mbsp_pkg::OP_FEED, 8'hF8, 1'b1, '{1'b0, 8'h00, 7'h00, 7'h00, 8'd1, 32'd3, 32'd1}},
		'{mbsp_pkg::OP_FEED, 8'hFF, 1'b1, '{1'b0, 8'h00, 7'h00, 7'h00, 8'd2, 32'd3, 32'd2}},
		'{mbsp_pkg::OP_POP, 8'h00, 1'b1, '{1'b1, 8'hF8, 7'h00, 7'h00, 8'd1, 32'd3, 32'd2}},
		'{mbsp_pkg::OP_FEED, 8'h90, 1'b0, '0},
		'{mbsp_pkg::OP_FEED, 8'h3C, 1'b0, '0},
		'{mbsp_pkg::OP_FEED, 8'h7F, 1'b0, '0},
		'{mbsp_pkg::OP_FEED, 8'h40, 1'b0, '0},
		'{mbsp_pkg::OP_FEED, 8'hF8, 1'b0, '0},
		'{mbsp_pkg::OP_FEED, 8'h00, 1'b0, '0},
		'{mbsp_pkg::OP_FEED, 8'hC3, 1'b0, '0},
		'{mbsp_pkg::OP_FEED, 8'h7F, 1'b0, '0},
		'{mbsp_pkg::OP_FEED, 8'h05, 1'b0, '0},
		'{mbsp_pkg::OP_FEED, mbsp_pkg::ST_SPP, 1'b0, '0},
		'{mbsp_pkg::OP_FEED, 8'h00, 1'b0, '0},
		'{mbsp_pkg::OP_FEED, 8'h7F, 1'b0, '0},
		'{mbsp_pkg::OP_FEED, mbsp_pkg::ST_MTC, 1'b0, '0},
		'{mbsp_pkg::OP_FEED, 8'h11, 1'b0, '0},
		'{mbsp_pkg::OP_FEED, mbsp_pkg::ST_SYSEX, 1'b0, '0},
		'{mbsp_pkg::OP_FEED, 8'h10, 1'b1, '{1'b0, 8'h00, 7'h00, 7'h00, 8'd8, 32'd4, 32'd9}},
		'{mbsp_pkg::OP_FEED, mbsp_pkg::ST_TUNE, 1'b0, '0},
		'{mbsp_pkg::OP_FEED, 8'hF7, 1'b0, '0}
	};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        op = mbsp_pkg::OP_FEED;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        msg_valid;
	logic [7:0]  msg_status;
	logic [6:0]  msg_first;
	logic [6:0]  msg_second;
	logic [7:0]  queued_count;
	logic [31:0] error_total;
	logic [31:0] message_total;

	bit     quiet = 1'b0;
	int     mismatches = 0;
	int     stuck = 0;
	reply_t pending_replies [$];

	// parser, queue and counter state kept on the testbench side
	logic [7:0]     run_status = '0;
	logic [6:0]     held [2] = '{7'h00, 7'h00};
	logic [1:0]     pos = '0;
	logic [1:0]     need = '0;
	mbsp_pkg::msg_t store [QUEUE_DEPTH];
	logic [6:0]     wr = '0;
	logic [6:0]     rd = '0;
	logic [7:0]     level = '0;
	logic [31:0]    errs = '0;
	logic [31:0]    msgs = '0;

	midi_byte_stream_parser #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.msg_valid(msg_valid),
		.msg_status(msg_status),
		.msg_first(msg_first),
		.msg_second(msg_second),
		.queued_count(queued_count),
		.error_total(error_total),
		.message_total(message_total)
	);

	function automatic int status_length(input logic [7:0] s);
		if (s >= mbsp_pkg::ST_RT_BASE) return 1;
		if (s >= mbsp_pkg::ST_SYS_BASE) begin
			if (s == mbsp_pkg::ST_MTC || s == mbsp_pkg::ST_SONG_SEL) return 2;
			if (s == mbsp_pkg::ST_SPP) return 3;
			return 1;
		end
		unique case (s[7:4])
			mbsp_pkg::NIB_PROGRAM, mbsp_pkg::NIB_PRESSURE: return 2;
			mbsp_pkg::NIB_NOTE_OFF, mbsp_pkg::NIB_NOTE_ON, mbsp_pkg::NIB_CTRL,
				mbsp_pkg::NIB_PITCH: return 3;
			default: return 0;
		endcase
	endfunction

	task automatic queue_msg(input logic [7:0] st, input logic [6:0] d1, input logic [6:0] d2);
		if (level >= QUEUE_DEPTH) begin
			errs = errs + 32'd1;
		end else begin
			store[wr] = '{second: d2, first: d1, status: st};
			wr = wr + 7'd1;
			level = level + 8'd1;
			msgs = msgs + 32'd1;
		end
	endtask

	task automatic parse_item(input logic item_op, input logic [7:0] value, output reply_t r);
		int len;
		logic [1:0] next_pos;
		r = '0;
		if (item_op == mbsp_pkg::OP_FEED) begin
			if (value[7]) begin
				if (value == mbsp_pkg::ST_SYSEX) begin
					run_status = '0;
					pos = '0;
					need = '0;
				end else begin
					len = status_length(value);
					if (len == 0) begin
						errs = errs + 32'd1;
					end else if (len == 1) begin
						queue_msg(value, 7'h00, 7'h00);
					end else begin
						run_status = value;
						pos = '0;
						need = 2'(len - 1);
					end
				end
			end else if (run_status == 8'h00 || need == 2'd0) begin
				errs = errs + 32'd1;
			end else begin
				held[pos[0]] = value[6:0];
				next_pos = pos + 2'd1;
				if (next_pos >= need) begin
					queue_msg(run_status, held[0], (need > 2'd1) ? held[1] : 7'h00);
					pos = '0;
				end else begin
					pos = next_pos;
				end
			end
		end else if (level > 0) begin
			r.msg_valid = 1'b1;
			r.msg_status = store[rd].status;
			r.msg_first = store[rd].first;
			r.msg_second = store[rd].second;
			rd = rd + 7'd1;
			level = level - 8'd1;
		end
		r.queued_count = level;
		r.error_total = errs;
		r.message_total = msgs;
	endtask

	// entered and left at a falling edge
	task automatic send_item(input logic item_op, input logic [7:0] value,
		input logic typed, input reply_t want);
		reply_t r;
		int gap;
		in_valid <= 1'b1;
		op <= item_op;
		data_byte <= value;
		do @(posedge clk); while (!in_ready);
		parse_item(item_op, value, r);
		pending_replies.push_back(typed ? want : r);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic send_message();
		logic [7:0] st;
		int k;
		int data_count;
		k = $urandom_range(0, 8);
		if (k < 6) begin
			st = {CHAN_NIBS[k], 4'($urandom_range(0, 15))};
		end else begin
			st = (k == 6) ? mbsp_pkg::ST_MTC : (k == 7) ? mbsp_pkg::ST_SPP :
				mbsp_pkg::ST_SONG_SEL;
		end
		data_count = status_length(st) - 1;
		send_item(mbsp_pkg::OP_FEED, st, 1'b0, '0);
		repeat ($urandom_range(1, 3)) begin
			for (int i = 0; i < data_count; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					send_item(mbsp_pkg::OP_FEED, 8'($urandom_range(8'hF8, 8'hFF)), 1'b0, '0);
				end
				send_item(mbsp_pkg::OP_FEED, 8'($urandom_range(0, 127)), 1'b0, '0);
			end
		end
	endtask

	task automatic random_mix(input int units);
		int pick;
		repeat (units) begin
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				send_item(mbsp_pkg::OP_POP, 8'($urandom_range(0, 255)), 1'b0, '0);
			end else if (pick < 8) begin
				send_message();
			end else begin
				send_item(mbsp_pkg::OP_FEED, 8'($urandom_range(0, 255)), 1'b0, '0);
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side back-pressure
	initial begin
		int hold;
		logic rdy;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				rdy = 1'b0;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				hold = $urandom_range(0, 3);
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
			end
			out_ready <= rdy;
		end
	end

	always @(posedge clk) begin
		reply_t got;
		reply_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{msg_valid, msg_status, msg_first, msg_second, queued_count,
				error_total, message_total};
			if (pending_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result beat: valid %0d status %02h first %02h second %02h",
						got.msg_valid, got.msg_status, got.msg_first, got.msg_second);
				end
			end else begin
				want = pending_replies.pop_front();
				if (got != want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: exp v%0d st %02h d1 %02h d2 %02h q %0d err %0d msg %0d",
							want.msg_valid, want.msg_status, want.msg_first, want.msg_second,
							want.queued_count, want.error_total, want.message_total);
						$display("          got v%0d st %02h d1 %02h d2 %02h q %0d err %0d msg %0d",
							got.msg_valid, got.msg_status, got.msg_first, got.msg_second,
							got.queued_count, got.error_total, got.message_total);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stuck <= 0;
		end else begin
			stuck <= stuck + 1;
			if (stuck >= STUCK_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			send_item(DIRECTED[i].op_bit, DIRECTED[i].value, DIRECTED[i].typed, DIRECTED[i].want);
		end

		random_mix(90);

		// overrun the queue, then drain it past empty
		repeat (QUEUE_DEPTH + 6) begin
			if ($urandom_range(0, 7) == 0) begin
				send_item(mbsp_pkg::OP_FEED, mbsp_pkg::ST_TUNE, 1'b0, '0);
			end else begin
				send_item(mbsp_pkg::OP_FEED, 8'($urandom_range(8'hF8, 8'hFF)), 1'b0, '0);
			end
		end
		repeat (QUEUE_DEPTH + 12) begin
			send_item(mbsp_pkg::OP_POP, 8'($urandom_range(0, 255)), 1'b0, '0);
		end

		quiet = 1'b1;
		random_mix(15);
		in_valid <= 1'b0;

		while (pending_replies.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
